/* src/tpro_pkg.sv */
package tpro_pkg;

    // Default size of the halfword buffer
    localparam int BUFFER_DEPTH_DEF = 16;

    // Decode steps allowed before a walk is declared too long
    localparam int STEP_LIMIT = 16;

    // Entries in the front-to-back queue
    localparam int QUEUE_DEPTH = 2;

    // Stack pointer register number
    localparam logic [3:0] SP_REG = 4'd13;

    // Opcode patterns and masks
    localparam logic [15:0] OP_PUSH_LR    = 16'hb500;
    localparam logic [15:0] OP_WIDE_MIN   = 16'he800;
    localparam logic [15:0] OP_PUSH_W     = 16'he92d;
    localparam logic [15:0] OP_SUB_SP_EXP = 16'hf1ad;
    localparam logic [15:0] OP_SUB_SP_I12 = 16'hf2ad;
    localparam logic [15:0] OP_STR_PRE    = 16'hf84d;
    localparam logic [15:0] OP_VPUSH      = 16'hed2d;
    localparam logic [11:0] STR_PRE_TAIL  = 12'hd04;
    localparam logic [15:0] MASK_EXP      = 16'hfbef;
    localparam logic [15:0] MASK_I12      = 16'hfbff;
    localparam logic [15:0] MASK_IMM7     = 16'hff80;
    localparam logic [15:0] OP_SUB_SP_I7  = 16'hb080;
    localparam logic [15:0] OP_ADD_SP_I7  = 16'hb000;
    localparam logic [15:0] OP_ADD_SP_EXP = 16'hf10d;
    localparam logic [15:0] MASK_PUSH16   = 16'hfe00;
    localparam logic [15:0] OP_PUSH16     = 16'hb400;
    localparam logic [15:0] MASK_TOP5     = 16'hf800;
    localparam logic [15:0] OP_ADD_SP_REG = 16'ha800;
    localparam logic [15:0] OP_LDR_LIT    = 16'h4800;
    localparam logic [15:0] OP_BL_HI      = 16'hf000;
    localparam logic [15:0] MASK_VPUSH    = 16'hffbf;
    localparam logic [15:0] MASK_LDR_W    = 16'hfff0;
    localparam logic [15:0] OP_LDR_W      = 16'hf8d0;

    // Input item
    typedef struct packed {
        logic [15:0] halfword;
        logic        last;
    } load_item_t;

    // Result item
    typedef struct packed {
        logic signed [31:0] ret_offset;
        logic               found;
        logic               unknown_seen;
        logic               long_prologue;
    } result_item_t;

    // Effect of one decoded instruction on the walk
    typedef enum logic [2:0] {
        K_NONE,
        K_PUSH,
        K_ADD,
        K_SUB,
        K_PATTERN,
        K_UNKNOWN
    } kind_t;

    // Record passed from the decoder to the accumulator
    typedef struct packed {
        kind_t       kind;
        logic        force_lr;
        logic [31:0] amount;
        logic        end_walk;
        logic        long_walk;
    } rec_t;

endpackage

/* src/tpro_front.sv */
module tpro_front #(
    parameter int BUFFER_DEPTH = tpro_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_valid,
    output logic                 load_ready,
    input  tpro_pkg::load_item_t load_item,
    output logic                 push_valid,
    input  logic                 push_ready,
    output tpro_pkg::rec_t       push_rec
);

    localparam int LCW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int FPW = $clog2(BUFFER_DEPTH + 2 * tpro_pkg::STEP_LIMIT + 8);
    localparam int STW = $clog2(tpro_pkg::STEP_LIMIT + 1);

    typedef enum logic [1:0] {
        S_LOAD,
        S_FETCH,
        S_SHIFT,
        S_DECODE
    } state_t;

    state_t           state_reg;
    logic [LCW-1:0]   lc_reg;
    logic [FPW-1:0]   fp_reg;
    logic [1:0]       need_reg;
    logic [STW-1:0]   step_reg;
    logic [15:0]      w0_reg, w1_reg, w2_reg;
    logic [15:0]      rd_data_reg;
    logic             rd_hit_reg;
    logic [15:0]      hw_mem [BUFFER_DEPTH];

    logic             load_fire;
    logic             push_fire;
    logic             has_room;
    logic             rd_hit;
    logic [AW-1:0]    rd_addr;
    logic [1:0]       size;
    logic             at_limit;
    logic [31:0]      exp_val;
    logic [11:0]      imm12;
    logic             sp_dst;

    function automatic logic [3:0] count_ones13(input logic [12:0] v);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 13; i++)
        begin
            c = c + 4'(v[i]);
        end
        return c;
    endfunction

    // Thumb modified immediate
    function automatic logic [31:0] expand_imm(input logic [15:0] h1, input logic [15:0] h2);
        logic [3:0]  up;
        logic [7:0]  lo;
        logic [4:0]  sh;
        logic [31:0] v;
        logic [31:0] r;
        up = {h1[10], h2[14:12]};
        lo = h2[7:0];
        sh = {up, lo[7]};
        v  = {24'b0, 1'b1, lo[6:0]};
        if (up[3:2] == 2'b00)
        begin
            unique case (up[1:0])
                2'd0:    r = {24'b0, lo};
                2'd1:    r = {8'b0, lo, 8'b0, lo};
                2'd2:    r = {lo, 8'b0, lo, 8'b0};
                default: r = {lo, lo, lo, lo};
            endcase
        end
        else
        begin
            // rotate right, amount is 8..31 here
            r = (v >> sh) | (v << (6'd32 - {1'b0, sh}));
        end
        return r;
    endfunction

    assign load_ready = (state_reg == S_LOAD);
    assign load_fire  = load_valid && load_ready;
    assign push_valid = (state_reg == S_DECODE);
    assign push_fire  = push_valid && push_ready;
    assign has_room   = (lc_reg < LCW'(BUFFER_DEPTH));

    // Halfwords beyond the loaded count read as zero
    assign rd_hit  = (fp_reg < FPW'(lc_reg));
    assign rd_addr = rd_hit ? fp_reg[AW-1:0] : '0;

    // Buffer memory
    always_ff @(posedge clk)
    begin
        if (load_fire && has_room)
        begin
            hw_mem[lc_reg[AW-1:0]] <= load_item.halfword;
        end
        rd_data_reg <= hw_mem[rd_addr];
    end

    // Decode window shift
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FETCH)
        begin
            rd_hit_reg <= rd_hit;
        end
        if (state_reg == S_SHIFT)
        begin
            w0_reg <= w1_reg;
            w1_reg <= w2_reg;
            w2_reg <= rd_hit_reg ? rd_data_reg : 16'h0000;
        end
    end

    // Classify the instruction at the head of the window
    assign size     = (w0_reg >= tpro_pkg::OP_WIDE_MIN) ? 2'd2 : 2'd1;
    assign at_limit = (step_reg == STW'(tpro_pkg::STEP_LIMIT));
    assign exp_val  = expand_imm(w0_reg, w1_reg);
    assign imm12    = {w0_reg[10], w1_reg[14:12], w1_reg[7:0]};
    assign sp_dst   = (w1_reg[11:8] == tpro_pkg::SP_REG);

    always_comb
    begin
        push_rec          = '0;
        push_rec.kind     = tpro_pkg::K_NONE;
        priority if (w0_reg == tpro_pkg::OP_PUSH_LR
                     && (w1_reg & tpro_pkg::MASK_TOP5) == tpro_pkg::OP_BL_HI
                     && w2_reg[15:14] == 2'b11)
        begin
            push_rec.kind = tpro_pkg::K_PATTERN;
        end
        else if ((w0_reg & tpro_pkg::MASK_PUSH16) == tpro_pkg::OP_PUSH16)
        begin
            push_rec.kind     = tpro_pkg::K_PUSH;
            push_rec.force_lr = w0_reg[8];
            push_rec.amount   = 32'(count_ones13({5'b0, w0_reg[7:0]}));
        end
        else if (w0_reg == tpro_pkg::OP_PUSH_W)
        begin
            push_rec.kind     = tpro_pkg::K_PUSH;
            push_rec.force_lr = w1_reg[14];
            push_rec.amount   = 32'(count_ones13(w1_reg[12:0]));
        end
        else if ((w0_reg & tpro_pkg::MASK_IMM7) == tpro_pkg::OP_SUB_SP_I7)
        begin
            push_rec.kind   = tpro_pkg::K_ADD;
            push_rec.amount = 32'(w0_reg[6:0]);
        end
        else if ((w0_reg & tpro_pkg::MASK_EXP) == tpro_pkg::OP_SUB_SP_EXP)
        begin
            push_rec.kind   = sp_dst ? tpro_pkg::K_ADD : tpro_pkg::K_NONE;
            push_rec.amount = {2'b00, exp_val[31:2]};
        end
        else if ((w0_reg & tpro_pkg::MASK_I12) == tpro_pkg::OP_SUB_SP_I12)
        begin
            push_rec.kind   = sp_dst ? tpro_pkg::K_ADD : tpro_pkg::K_NONE;
            push_rec.amount = 32'(imm12[11:2]);
        end
        else if ((w0_reg & tpro_pkg::MASK_TOP5) == tpro_pkg::OP_ADD_SP_REG)
        begin
            // 3-bit target field never names SP
            push_rec.kind = tpro_pkg::K_NONE;
        end
        else if ((w0_reg & tpro_pkg::MASK_IMM7) == tpro_pkg::OP_ADD_SP_I7)
        begin
            push_rec.kind   = tpro_pkg::K_SUB;
            push_rec.amount = 32'(w0_reg[6:0]);
        end
        else if ((w0_reg & tpro_pkg::MASK_EXP) == tpro_pkg::OP_ADD_SP_EXP)
        begin
            push_rec.kind   = sp_dst ? tpro_pkg::K_SUB : tpro_pkg::K_NONE;
            push_rec.amount = {2'b00, exp_val[31:2]};
        end
        else if (w0_reg == tpro_pkg::OP_STR_PRE)
        begin
            push_rec.kind   = (w1_reg[11:0] == tpro_pkg::STR_PRE_TAIL)
                              ? tpro_pkg::K_ADD : tpro_pkg::K_NONE;
            push_rec.amount = 32'd1;
        end
        else if ((w0_reg & tpro_pkg::MASK_VPUSH) == tpro_pkg::OP_VPUSH)
        begin
            push_rec.kind   = tpro_pkg::K_ADD;
            push_rec.amount = 32'(w1_reg[7:0]);
        end
        else if ((w0_reg & tpro_pkg::MASK_TOP5) == tpro_pkg::OP_LDR_LIT)
        begin
            push_rec.kind = tpro_pkg::K_NONE;
        end
        else if ((w0_reg & tpro_pkg::MASK_LDR_W) == tpro_pkg::OP_LDR_W)
        begin
            push_rec.kind = tpro_pkg::K_NONE;
        end
        else
        begin
            push_rec.kind = tpro_pkg::K_UNKNOWN;
        end
        push_rec.end_walk  = (push_rec.kind == tpro_pkg::K_PATTERN) || at_limit;
        push_rec.long_walk = (push_rec.kind != tpro_pkg::K_PATTERN) && at_limit;
    end

    // Load and walk sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            lc_reg    <= '0;
            fp_reg    <= '0;
            need_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (load_fire)
                    begin
                        if (has_room)
                        begin
                            lc_reg <= lc_reg + 1'b1;
                        end
                        if (load_item.last)
                        begin
                            state_reg <= S_FETCH;
                            fp_reg    <= '0;
                            need_reg  <= 2'd3;
                            step_reg  <= '0;
                        end
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    fp_reg    <= fp_reg + 1'b1;
                    need_reg  <= need_reg - 1'b1;
                    state_reg <= (need_reg == 2'd1) ? S_DECODE : S_FETCH;
                end
                S_DECODE:
                begin
                    if (push_fire)
                    begin
                        if (push_rec.end_walk)
                        begin
                            state_reg <= S_LOAD;
                            lc_reg    <= '0;
                            step_reg  <= '0;
                        end
                        else
                        begin
                            state_reg <= S_FETCH;
                            need_reg  <= size;
                            step_reg  <= step_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        push_fire |-> step_reg <= STW'(tpro_pkg::STEP_LIMIT))
        else $error("walk step count passed the limit");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        push_fire && push_rec.end_walk |=> state_reg == S_LOAD && lc_reg == '0)
        else $error("walk end did not reopen loading");

    a_window_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT && need_reg == 2'd1 |=> state_reg == S_DECODE)
        else $error("decode entered with partial window");
`endif

endmodule

/* src/tpro_queue.sv */
module tpro_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  tpro_pkg::rec_t push_rec,
    output logic           pop_valid,
    input  logic           pop_ready,
    output tpro_pkg::rec_t pop_rec
);

    localparam int QD  = tpro_pkg::QUEUE_DEPTH;
    localparam int QPW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    tpro_pkg::rec_t  slot_reg [QD];
    logic [QPW-1:0]  wp_reg, rp_reg;
    logic [QCW-1:0]  count_reg;
    logic            push_fire, pop_fire;

    assign push_ready = (count_reg != QCW'(QD));
    assign pop_valid  = (count_reg != '0);
    assign pop_rec    = slot_reg[rp_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wp_reg] <= push_rec;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wp_reg <= (wp_reg == QPW'(QD - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rp_reg <= (rp_reg == QPW'(QD - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_full_stays: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && !push_ready |=> pop_valid)
        else $error("full queue lost its entries");
`endif

endmodule

/* src/tpro_back.sv */
module tpro_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  tpro_pkg::rec_t         pop_rec,
    output logic                   result_valid,
    input  logic                   result_ready,
    output tpro_pkg::result_item_t result_item
);

    logic [31:0]            offset_reg, offset_next;
    logic                   lr_reg, lr_next;
    logic                   unk_reg, unk_next;
    logic                   found_next;
    logic                   out_valid_reg;
    tpro_pkg::result_item_t out_item_reg;
    logic                   pop_fire;

    // An ending record waits until the output slot is free
    assign pop_ready    = !pop_rec.end_walk || !out_valid_reg || result_ready;
    assign pop_fire     = pop_valid && pop_ready;
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    // Apply one record to the running offset
    always_comb
    begin
        offset_next = offset_reg;
        lr_next     = lr_reg;
        unk_next    = unk_reg;
        found_next  = 1'b0;
        unique case (pop_rec.kind)
            tpro_pkg::K_PUSH:
            begin
                if (pop_rec.force_lr || lr_reg)
                begin
                    lr_next     = 1'b1;
                    offset_next = offset_reg + pop_rec.amount;
                end
            end
            tpro_pkg::K_ADD:
            begin
                if (lr_reg)
                begin
                    offset_next = offset_reg + pop_rec.amount;
                end
            end
            tpro_pkg::K_SUB:
            begin
                if (lr_reg)
                begin
                    offset_next = offset_reg - pop_rec.amount;
                end
            end
            tpro_pkg::K_PATTERN:
            begin
                // tail call gives zero
                found_next  = 1'b1;
                offset_next = lr_reg ? offset_reg + 32'd1 : 32'd0;
            end
            tpro_pkg::K_UNKNOWN:
            begin
                unk_next = 1'b1;
            end
            default:
            begin
                offset_next = offset_reg;
            end
        endcase
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (pop_fire && pop_rec.end_walk)
        begin
            out_item_reg.ret_offset    <= $signed(offset_next);
            out_item_reg.found         <= found_next;
            out_item_reg.unknown_seen  <= unk_next;
            out_item_reg.long_prologue <= pop_rec.long_walk;
        end
    end

    // Walk state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            lr_reg        <= 1'b0;
            unk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_fire && pop_rec.end_walk)
            begin
                offset_reg    <= '0;
                lr_reg        <= 1'b0;
                unk_reg       <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (pop_fire)
                begin
                    offset_reg <= offset_next;
                    lr_reg     <= lr_next;
                    unk_reg    <= unk_next;
                end
                if (result_ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire && pop_rec.end_walk && out_valid_reg |-> result_ready)
        else $error("result overwritten before it was taken");

    a_found_not_long: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_item_reg.found && out_item_reg.long_prologue))
        else $error("result both found and long");

    a_cleared_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire && pop_rec.end_walk |=> offset_reg == '0 && !lr_reg && !unk_reg)
        else $error("walk state not cleared after result");
`endif

endmodule

/* src/thumb_prologue_return_offset_core.sv */
// Thumb-2 prologue return-offset analyzer.
// load channel: one item per halfword of a prologue, in memory order. The item
//   with last set closes the buffer and starts the walk. Up to BUFFER_DEPTH
//   halfwords are kept; later ones are dropped, but last still starts the walk.
// result channel: one item per walk, with the word offset of the saved return
//   address and the found, unknown_seen and long_prologue flags.
// Throughput: one halfword accepted per cycle while loading. load_ready stays
//   low from the last halfword until the decoder has issued its final step.
// Walk: the window fills with three halfwords, each through a fetch and a shift
//   state; each decode step then refetches size halfwords (size 1 or 2) the same
//   way, through the single read port of the buffer memory; at most
//   STEP_LIMIT + 1 = 17 steps. The final record passes the queue slot register
//   and then lands in the result register.
// Stall: a result waits in an output register; the next walk's decoder keeps
//   running into a two-entry queue and halts only when the queue is full.
// Reset: rst_n is asynchronous, active low; the buffer, counts and walk state
//   are empty afterwards and no result is pending.
module thumb_prologue_return_offset_core #(
    parameter int BUFFER_DEPTH = tpro_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load_valid,
    output logic                   load_ready,
    input  tpro_pkg::load_item_t   load_item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output tpro_pkg::result_item_t result_item
);

    logic           f_valid, f_ready;
    tpro_pkg::rec_t f_rec;
    logic           b_valid, b_ready;
    tpro_pkg::rec_t b_rec;

    // Loader and decoder
    tpro_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (load_valid),
        .load_ready (load_ready),
        .load_item  (load_item),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_rec   (f_rec)
    );

    // Decoded-record queue
    tpro_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_rec   (f_rec),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_rec    (b_rec)
    );

    // Offset accumulator and result register
    tpro_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (b_valid),
        .pop_ready    (b_ready),
        .pop_rec      (b_rec),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule

/* dv/thumb_prologue_return_offset_core_tb.sv */
`timescale 1ns / 1ps

module thumb_prologue_return_offset_core_tb;

    localparam int DEPTH        = tpro_pkg::BUFFER_DEPTH_DEF;
    localparam int DIRECTED_CNT = 25;
    localparam int RANDOM_CNT   = 1200;
    localparam int MAX_PRINTS   = 100;

    // Scoreboard: tracks the loaded prologue and predicts each walk result
    class ret_offset_board;

        logic [15:0]            halfwords [DEPTH];
        int unsigned            fill_cnt;
        logic [31:0]            offs;
        bit                     lr_seen;
        int unsigned            rd_pos;
        int unsigned            steps;
        bit                     unk;
        tpro_pkg::result_item_t expected_walks [$];
        int                     errors;

        function new();
            fill_cnt = 0;
            errors = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            fill_cnt = 0;
            offs = '0;
            lr_seen = 0;
            rd_pos = 0;
            steps = 0;
            unk = 0;
        endfunction

        function int pending();
            return expected_walks.size();
        endfunction

        // Halfwords beyond what was loaded read as zero
        function logic [15:0] fetch(int unsigned idx);
            if (idx < fill_cnt && idx < DEPTH)
                return halfwords[idx];
            return 16'h0000;
        endfunction

        // ThumbExpandImm from i:imm3:imm8
        function logic [31:0] expand_imm(logic [15:0] h1, logic [15:0] h2);
            logic [3:0]  up;
            logic [7:0]  lo;
            logic [4:0]  sh;
            logic [31:0] v;
            up = {h1[10], h2[14:12]};
            lo = h2[7:0];
            if (up[3:2] == 2'b00)
            begin
                case (up[1:0])
                    2'd0: return {24'h0, lo};
                    2'd1: return {8'h0, lo, 8'h0, lo};
                    2'd2: return {lo, 8'h0, lo, 8'h0};
                    default: return {4{lo}};
                endcase
            end
            sh = {up, lo[7]};
            v = {24'h0, 1'b1, lo[6:0]};
            return (v >> sh) | (v << (32 - int'(sh)));
        endfunction

        // One decode step; returns halfwords consumed, zero on the return pattern
        function int unsigned decode_step();
            logic [15:0] op;
            logic [15:0] h2;
            logic [15:0] h3;
            logic [31:0] imm;
            int unsigned size;
            op = fetch(rd_pos);
            h2 = fetch(rd_pos + 1);
            h3 = fetch(rd_pos + 2);
            size = (op >= tpro_pkg::OP_WIDE_MIN) ? 2 : 1;
            if (op == tpro_pkg::OP_PUSH_LR
                && (h2 & tpro_pkg::MASK_TOP5) == tpro_pkg::OP_BL_HI
                && h3[15:14] == 2'b11)
            begin
                // tail call when no LR push came first
                if (lr_seen)
                    offs = offs + 1;
                else
                    offs = '0;
                return 0;
            end
            else if ((op & tpro_pkg::MASK_PUSH16) == tpro_pkg::OP_PUSH16)
            begin
                if (op[8] || lr_seen)
                begin
                    lr_seen = 1;
                    offs = offs + $countones(op[7:0]);
                end
            end
            else if (op == tpro_pkg::OP_PUSH_W)
            begin
                if (h2[14] || lr_seen)
                begin
                    lr_seen = 1;
                    offs = offs + $countones(h2[12:0]);
                end
            end
            else if ((op & tpro_pkg::MASK_IMM7) == tpro_pkg::OP_SUB_SP_I7)
            begin
                if (lr_seen)
                    offs = offs + op[6:0];
            end
            else if ((op & tpro_pkg::MASK_EXP) == tpro_pkg::OP_SUB_SP_EXP)
            begin
                if (lr_seen && h2[11:8] == tpro_pkg::SP_REG)
                    offs = offs + (expand_imm(op, h2) >> 2);
            end
            else if ((op & tpro_pkg::MASK_I12) == tpro_pkg::OP_SUB_SP_I12)
            begin
                if (lr_seen && h2[11:8] == tpro_pkg::SP_REG)
                begin
                    imm = {20'h0, op[10], h2[14:12], h2[7:0]};
                    offs = offs + (imm >> 2);
                end
            end
            else if ((op & tpro_pkg::MASK_TOP5) == tpro_pkg::OP_ADD_SP_REG)
            begin
                // 3-bit target can never name SP
                if (lr_seen && {1'b0, op[9:7]} == tpro_pkg::SP_REG)
                    offs = offs - op[7:0];
            end
            else if ((op & tpro_pkg::MASK_IMM7) == tpro_pkg::OP_ADD_SP_I7)
            begin
                if (lr_seen)
                    offs = offs - op[6:0];
            end
            else if ((op & tpro_pkg::MASK_EXP) == tpro_pkg::OP_ADD_SP_EXP)
            begin
                if (lr_seen && h2[11:8] == tpro_pkg::SP_REG)
                    offs = offs - (expand_imm(op, h2) >> 2);
            end
            else if (op == tpro_pkg::OP_STR_PRE)
            begin
                if (lr_seen && h2[11:0] == tpro_pkg::STR_PRE_TAIL)
                    offs = offs + 1;
            end
            else if ((op & tpro_pkg::MASK_VPUSH) == tpro_pkg::OP_VPUSH)
            begin
                if (lr_seen)
                    offs = offs + h2[7:0];
            end
            else if ((op & tpro_pkg::MASK_TOP5) == tpro_pkg::OP_LDR_LIT)
            begin
                // no stack effect
            end
            else if ((op & tpro_pkg::MASK_LDR_W) == tpro_pkg::OP_LDR_W)
            begin
                // no stack effect
            end
            else
            begin
                unk = 1;
            end
            return size;
        endfunction

        // Store an accepted halfword; last runs the walk and queues the outcome
        function void load_halfword(tpro_pkg::load_item_t it);
            int unsigned            used;
            bit                     too_long;
            tpro_pkg::result_item_t res;
            if (fill_cnt < DEPTH)
            begin
                halfwords[fill_cnt] = it.halfword;
                fill_cnt++;
            end
            if (!it.last)
                return;
            too_long = 0;
            while (1)
            begin
                used = decode_step();
                rd_pos += used;
                if (used == 0)
                    break;
                if (steps >= tpro_pkg::STEP_LIMIT)
                begin
                    too_long = 1;
                    break;
                end
                steps++;
            end
            res.ret_offset    = offs;
            res.found         = (used == 0);
            res.unknown_seen  = unk;
            res.long_prologue = too_long;
            expected_walks.push_back(res);
            clear_walk();
        endfunction

        task flag_mismatch(string msg);
            if (errors < MAX_PRINTS)
                $display("%0t MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_walk_result(tpro_pkg::result_item_t got);
            tpro_pkg::result_item_t want;
            if (expected_walks.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result, ret_offset=%0d", got.ret_offset));
                return;
            end
            want = expected_walks.pop_front();
            if (got.ret_offset !== want.ret_offset)
                flag_mismatch($sformatf("ret_offset got %0d want %0d",
                                        got.ret_offset, want.ret_offset));
            if (got.found !== want.found)
                flag_mismatch($sformatf("found got %b want %b", got.found, want.found));
            if (got.unknown_seen !== want.unknown_seen)
                flag_mismatch($sformatf("unknown_seen got %b want %b",
                                        got.unknown_seen, want.unknown_seen));
            if (got.long_prologue !== want.long_prologue)
                flag_mismatch($sformatf("long_prologue got %b want %b",
                                        got.long_prologue, want.long_prologue));
        endtask

    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   load_valid;
    logic                   load_ready;
    tpro_pkg::load_item_t   load_item;
    logic                   result_valid;
    logic                   result_ready;
    tpro_pkg::result_item_t result_item;

    ret_offset_board board = new();
    logic [15:0]     prologue [$];
    int              items_sent;
    bit              no_idle;

    thumb_prologue_return_offset_core #(
        .BUFFER_DEPTH(DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (load_valid),
        .load_ready  (load_ready),
        .load_item   (load_item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result_item (result_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Monitor both channels
    always @(posedge clk)
    begin
        if (rst_n && load_valid && load_ready)
            board.load_halfword(load_item);
        if (rst_n && result_valid && result_ready)
            board.check_walk_result(result_item);
    end

    // Result backpressure: mostly ready, short stalls, a few long ones
    initial
    begin
        int r;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                result_ready <= 1'b1;
                repeat ($urandom_range(1, 80)) @(posedge clk);
            end
            else if (r < 90)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
        end
    end

    function int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic send_halfword(input logic [15:0] hw, input logic fin);
        tpro_pkg::load_item_t li;
        int                   gap;
        li.halfword = hw;
        li.last     = fin;
        load_item  <= li;
        load_valid <= 1'b1;
        do
            @(posedge clk);
        while (!load_ready);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            load_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_prologue();
        for (int i = 0; i < prologue.size(); i++)
            send_halfword(prologue[i], i == prologue.size() - 1);
    endtask

    // Free bits 10 and 4 of the wide SP-immediate opcodes
    function logic [15:0] wide_free();
        return {5'b0, 1'($urandom), 5'b0, 1'($urandom), 4'b0};
    endfunction

    // Second halfword that usually names SP as destination
    function logic [15:0] sp_h2();
        logic [15:0] w;
        w = 16'($urandom);
        if ($urandom_range(0, 3) != 0)
            w[11:8] = tpro_pkg::SP_REG;
        return w;
    endfunction

    task automatic add_insn();
        logic [15:0] w;
        case ($urandom_range(0, 13))
            0: prologue.push_back(tpro_pkg::OP_PUSH16 | 16'($urandom_range(0, 511)));
            1:
            begin
                prologue.push_back(tpro_pkg::OP_PUSH_W);
                prologue.push_back(16'($urandom));
            end
            2: prologue.push_back(tpro_pkg::OP_SUB_SP_I7 | 16'($urandom_range(0, 127)));
            3:
            begin
                prologue.push_back(tpro_pkg::OP_SUB_SP_EXP | wide_free());
                prologue.push_back(sp_h2());
            end
            4:
            begin
                prologue.push_back(tpro_pkg::OP_SUB_SP_I12 | {5'b0, 1'($urandom), 10'b0});
                prologue.push_back(sp_h2());
            end
            5: prologue.push_back(tpro_pkg::OP_ADD_SP_REG | 16'($urandom_range(0, 2047)));
            6: prologue.push_back(tpro_pkg::OP_ADD_SP_I7 | 16'($urandom_range(0, 127)));
            7:
            begin
                prologue.push_back(tpro_pkg::OP_ADD_SP_EXP | wide_free());
                prologue.push_back(sp_h2());
            end
            8:
            begin
                prologue.push_back(tpro_pkg::OP_STR_PRE);
                prologue.push_back(($urandom_range(0, 3) != 0) ?
                                   {4'($urandom), tpro_pkg::STR_PRE_TAIL} : 16'($urandom));
            end
            9:
            begin
                prologue.push_back(tpro_pkg::OP_VPUSH | {9'b0, 1'($urandom), 6'b0});
                prologue.push_back(16'($urandom));
            end
            10: prologue.push_back(tpro_pkg::OP_LDR_LIT | 16'($urandom_range(0, 2047)));
            11:
            begin
                prologue.push_back(tpro_pkg::OP_LDR_W | 16'($urandom_range(0, 15)));
                prologue.push_back(16'($urandom));
            end
            12:
            begin
                w = 16'($urandom);
                prologue.push_back(w);
                if (w >= tpro_pkg::OP_WIDE_MIN)
                    prologue.push_back(16'($urandom));
            end
            default: prologue.push_back(16'h0000);
        endcase
    endtask

    // PUSH {LR} then BL; sometimes broken or cut short
    task automatic add_pattern();
        prologue.push_back(tpro_pkg::OP_PUSH_LR);
        if ($urandom_range(0, 7) == 0)
        begin
            prologue.push_back(16'($urandom));
            return;
        end
        prologue.push_back(tpro_pkg::OP_BL_HI | 16'($urandom_range(0, 2047)));
        if ($urandom_range(0, 7) != 0)
            prologue.push_back(16'hc000 | 16'($urandom_range(0, 16383)));
    endtask

    task automatic build_random_prologue();
        int kind;
        int n;
        prologue.delete();
        no_idle = ($urandom_range(0, 3) == 0);
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            // noise
            n = $urandom_range(1, 20);
            repeat (n) prologue.push_back(16'($urandom));
        end
        else
        begin
            n = (kind < 25) ? $urandom_range(8, 12) : $urandom_range(0, 6);
            repeat (n) add_insn();
            if ($urandom_range(0, 9) < 7)
                add_pattern();
            if ($urandom_range(0, 4) == 0 || prologue.size() == 0)
                add_insn();
        end
    endtask

    initial
    begin
        int wait_cycles;
        rst_n      = 1'b0;
        load_valid = 1'b0;
        load_item  = '0;
        items_sent = 0;
        no_idle    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: push list + sub + return pattern
        prologue = {16'hb5f0, 16'hb082, 16'hb500, 16'hf000, 16'hf800};
        send_prologue();
        // Lone zero halfword: unknown, reads past load, runs into the step limit
        prologue = {16'h0000};
        send_prologue();
        // Wide forms: PUSH.W, SUB.W expand, SUB imm12, VPUSH, STR pre-decrement
        prologue = {16'he92d, 16'h4ff0, 16'hf1ad, 16'h0d10, 16'hf2ad,
                    16'h0d04, 16'hed2d, 16'h8b04, 16'hf84d, 16'h4d04};
        send_prologue();
        // ADD SP register form, ADD SP imm7, ADD.W rotated imm, loads, extremes
        prologue = {16'hb501, 16'ha8ff, 16'hb07f, 16'hf50d, 16'h5d80,
                    16'h4801, 16'hf8d0, 16'h0000, 16'hffff};
        send_prologue();

        // Random prologues
        while (items_sent < DIRECTED_CNT + RANDOM_CNT)
        begin
            build_random_prologue();
            send_prologue();
        end
        load_valid <= 1'b0;

        // Drain
        wait_cycles = 0;
        while (board.pending() > 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (board.pending() > 0)
            board.flag_mismatch($sformatf("%0d results never arrived", board.pending()));
        repeat (120) @(posedge clk);

        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
